### src/voice_frame_fec_packer_assert.svh
// Assertion macros for the voice frame FEC packer.
`ifndef VOICE_FRAME_FEC_PACKER_ASSERT_SVH
`define VOICE_FRAME_FEC_PACKER_ASSERT_SVH

// Same-cycle implication, checked on i_clk, off during reset.
`define VFFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vffp: same-cycle check failed");

// Next-cycle implication, checked on i_clk, off during reset.
`define VFFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vffp: next-cycle check failed");

`endif

### src/vffp_pkg.sv
// Package: word types, register indexes, scrambler constants and interleave tables.
`default_nettype none
package vffp_pkg;

    localparam int CFG_W   = 44;
    localparam int GW_W    = 11;
    localparam int GW_N    = 12;
    localparam int DATA_W  = 12;
    localparam int ROW_W   = 24;
    localparam int ROW2_W  = 11;
    localparam int ROW3_W  = 14;
    localparam int LCG_N   = 23;
    localparam int FRAME_W = 72;

    localparam int LCG_MUL = 173;
    localparam int LCG_INC = 13849;
    localparam int LCG_MOD = 65536;
    localparam int LCG_TOP = 32768;

    // register indexes
    localparam logic [1:0] CFG_IDX_A = 2'd0;
    localparam logic [1:0] CFG_IDX_B = 2'd1;
    localparam logic [1:0] CFG_IDX_C = 2'd2;

    typedef struct packed {
        logic [6:0] pitch_index;
        logic [4:0] param_one;
        logic [4:0] param_two;
        logic [8:0] param_three;
        logic [6:0] param_four;
        logic [4:0] param_five;
        logic [3:0] param_six;
        logic [3:0] param_seven;
        logic [2:0] param_eight;
    } t_in_word;

    typedef struct packed {
        logic [7:0] frame_byte_0;
        logic [7:0] frame_byte_1;
        logic [7:0] frame_byte_2;
        logic [7:0] frame_byte_3;
        logic [7:0] frame_byte_4;
        logic [7:0] frame_byte_5;
        logic [7:0] frame_byte_6;
        logic [7:0] frame_byte_7;
        logic [7:0] frame_byte_8;
    } t_out_word;

    typedef logic [GW_N-1:0][GW_W-1:0] t_gen_words;

    typedef struct packed {
        logic [DATA_W-1:0] d0;
        logic [DATA_W-1:0] d1;
        logic [ROW2_W-1:0] row2;
        logic [ROW3_W-1:0] row3;
    } t_pack_word;

    // prod[k] holds the low 12 bits of A(k+1) * d0; the seed's low nibble is zero
    typedef struct packed {
        logic [DATA_W-1:0]             d0;
        logic [DATA_W-1:0]             d1;
        logic [ROW2_W-1:0]             row2;
        logic [ROW3_W-1:0]             row3;
        logic [GW_W-1:0]               par0;
        logic [GW_W-1:0]               par1;
        logic [LCG_N-1:0][DATA_W-1:0]  prod;
    } t_code_word;

    // n-step LCG: x_n = A_n * seed + C_n (mod 2^16)
    function automatic logic [15:0] lcg_mul(input int n);
        int a;
        a = 1;
        for (int i = 0; i < n; i++) begin
            a = (a * LCG_MUL) % LCG_MOD;
        end
        return 16'(a);
    endfunction

    function automatic logic [15:0] lcg_inc(input int n);
        int c;
        c = 0;
        for (int i = 0; i < n; i++) begin
            c = (c * LCG_MUL + LCG_INC) % LCG_MOD;
        end
        return 16'(c);
    endfunction

    // serial bit i comes from row ROW_SEL[i], bit COL_SEL[i]
    localparam logic [1:0] ROW_SEL [FRAME_W] = '{
        2'd0, 2'd0, 2'd3, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0,
        2'd3, 2'd2, 2'd1, 2'd1, 2'd3, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd3, 2'd2,
        2'd0, 2'd0, 2'd3, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0,
        2'd3, 2'd2, 2'd1, 2'd1, 2'd3, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd3, 2'd2,
        2'd0, 2'd0, 2'd3, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0,
        2'd3, 2'd2, 2'd1, 2'd1, 2'd3, 2'd3, 2'd2, 2'd1, 2'd0, 2'd0, 2'd3, 2'd3
    };

    localparam logic [4:0] COL_SEL [FRAME_W] = '{
        5'd10, 5'd22, 5'd11, 5'd9,  5'd10, 5'd22, 5'd11, 5'd23, 5'd8,  5'd20, 5'd9,  5'd21,
        5'd10, 5'd8,  5'd9,  5'd21, 5'd8,  5'd6,  5'd7,  5'd19, 5'd8,  5'd20, 5'd9,  5'd7,
        5'd6,  5'd18, 5'd7,  5'd5,  5'd6,  5'd18, 5'd7,  5'd19, 5'd4,  5'd16, 5'd5,  5'd17,
        5'd6,  5'd4,  5'd5,  5'd17, 5'd4,  5'd2,  5'd3,  5'd15, 5'd4,  5'd16, 5'd5,  5'd3,
        5'd2,  5'd14, 5'd3,  5'd1,  5'd2,  5'd14, 5'd3,  5'd15, 5'd0,  5'd12, 5'd1,  5'd13,
        5'd2,  5'd0,  5'd1,  5'd13, 5'd0,  5'd12, 5'd10, 5'd11, 5'd0,  5'd12, 5'd1,  5'd13
    };

endpackage
`default_nettype wire

### src/voice_frame_fec_packer.sv
// 3 register stages (pack, code, out) lie between an accepted input word and its output word.
// Throughput: one word per cycle; each stage advances when it is empty or the next one takes.
// A stalled output holds its word while the earlier stages keep filling behind it.
// Reset (i_rst_n low, synchronous) clears all stage valid bits and the three generator
// registers to zero; configuration writes take effect on the next clock edge.
`default_nettype none
`include "voice_frame_fec_packer_assert.svh"
module voice_frame_fec_packer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_idx,
    input  wire logic [vffp_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire vffp_pkg::t_in_word            i_word,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output vffp_pkg::t_out_word                o_word
);

    logic [vffp_pkg::CFG_W-1:0] r_gw_a;
    logic [vffp_pkg::CFG_W-1:0] r_gw_b;
    logic [vffp_pkg::CFG_W-1:0] r_gw_c;
    vffp_pkg::t_gen_words       w_gen;

    logic                 w_v1;
    logic                 w_r1;
    vffp_pkg::t_pack_word w_word1;
    logic                 w_v2;
    logic                 w_r2;
    vffp_pkg::t_code_word w_word2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw_a <= '0;
            r_gw_b <= '0;
            r_gw_c <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vffp_pkg::CFG_IDX_A: r_gw_a <= i_cfg_data;
                vffp_pkg::CFG_IDX_B: r_gw_b <= i_cfg_data;
                vffp_pkg::CFG_IDX_C: r_gw_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // word i sits at bits 11*i of the concatenated registers
    assign w_gen = {r_gw_c, r_gw_b, r_gw_a};

    vffp_stage_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (i_word),
        .o_valid (w_v1),
        .i_ready (w_r1),
        .o_word  (w_word1)
    );

    vffp_stage_code u_code (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gen   (w_gen),
        .i_valid (w_v1),
        .o_ready (w_r1),
        .i_word  (w_word1),
        .o_valid (w_v2),
        .i_ready (w_r2),
        .o_word  (w_word2)
    );

    vffp_stage_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v2),
        .o_ready (w_r2),
        .i_word  (w_word2),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word)
    );

    // an empty output stage never back-pressures the input
    `VFFP_ASSERT_NOW(a_empty_out_ready, !o_valid, o_ready)
    // an accepted word always lands in the first stage
    `VFFP_ASSERT_NEXT(a_accept_fills, i_valid && o_ready, w_v1)
    // through an empty pipe an accepted word passes the pack, code and out registers to the output
    `VFFP_ASSERT_NOW(a_latency, i_valid && o_ready && !w_v1 && !w_v2 && !o_valid, ##3 o_valid)

endmodule
`default_nettype wire

### src/vffp_stage_pack.sv
// Stage 1: extracts the row data fields from the parameter indices.
`default_nettype none
module vffp_stage_pack (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire vffp_pkg::t_in_word i_word,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output vffp_pkg::t_pack_word    o_word
);

    logic                 r_valid;
    vffp_pkg::t_pack_word r_word;
    vffp_pkg::t_pack_word n_word;

    always_comb begin
        n_word.d0   = {i_word.pitch_index[6:3], i_word.param_one[4:1], i_word.param_two[4:1]};
        n_word.d1   = {i_word.param_three[8:1], i_word.param_four[6:3]};
        n_word.row2 = {i_word.param_five[4:1], i_word.param_six[3:1],
                       i_word.param_seven[3:1], i_word.param_eight[2]};
        n_word.row3 = {i_word.param_one[0], i_word.param_two[0], i_word.pitch_index[2:0],
                       i_word.param_three[0], i_word.param_four[2:0], i_word.param_five[0],
                       i_word.param_six[0], i_word.param_seven[0], i_word.param_eight[1:0]};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
`default_nettype wire

### src/vffp_stage_code.sv
// Stage 2: Golay parity of both coded rows and the scrambler seed products.
`default_nettype none
module vffp_stage_code (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire vffp_pkg::t_gen_words i_gen,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire vffp_pkg::t_pack_word i_word,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output vffp_pkg::t_code_word      o_word
);

    logic                 r_valid;
    vffp_pkg::t_code_word r_word;
    vffp_pkg::t_code_word n_word;
    logic [vffp_pkg::LCG_N-1:0][vffp_pkg::DATA_W-1:0] w_prod;

    // lane k: low bits of A(k+1) * d0, a constant multiply
    for (genvar k = 0; k < vffp_pkg::LCG_N; k++) begin : g_lane
        localparam logic [15:0] MUL_K = vffp_pkg::lcg_mul(k + 1);
        assign w_prod[k] = vffp_pkg::DATA_W'(i_word.d0 * MUL_K[vffp_pkg::DATA_W-1:0]);
    end

    always_comb begin
        n_word.d0   = i_word.d0;
        n_word.d1   = i_word.d1;
        n_word.row2 = i_word.row2;
        n_word.row3 = i_word.row3;
        n_word.prod = w_prod;
        n_word.par0 = '0;
        n_word.par1 = '0;
        for (int i = 0; i < vffp_pkg::GW_N; i++) begin
            if (i_word.d0[i]) n_word.par0 = n_word.par0 ^ i_gen[i];
            if (i_word.d1[i]) n_word.par1 = n_word.par1 ^ i_gen[i];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
`default_nettype wire

### src/vffp_stage_out.sv
// Stage 3: scrambles row 1, builds the rows and interleaves them into nine bytes.
`default_nettype none
module vffp_stage_out (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire vffp_pkg::t_code_word i_word,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output vffp_pkg::t_out_word       o_word
);

    logic                                        r_valid;
    vffp_pkg::t_out_word                         r_word;
    vffp_pkg::t_out_word                         n_word;
    logic [vffp_pkg::LCG_N-1:0]                  w_mask;
    logic [3:0][vffp_pkg::ROW_W-1:0]             w_rows;
    logic [vffp_pkg::FRAME_W-1:0]                w_bits;

    // step n = k+1 of the generator scrambles bit 22-k
    for (genvar k = 0; k < vffp_pkg::LCG_N; k++) begin : g_mask
        localparam logic [15:0] INC_K = vffp_pkg::lcg_inc(k + 1);
        logic [15:0] w_state;
        assign w_state = {i_word.prod[k], 4'b0000} + INC_K;
        assign w_mask[vffp_pkg::LCG_N-1-k] = w_state[15];
    end

    always_comb begin
        w_rows[0] = {i_word.d0, i_word.par0, ^{i_word.d0, i_word.par0}};
        w_rows[1] = {1'b0, {i_word.d1, i_word.par1} ^ w_mask};
        w_rows[2] = {(vffp_pkg::ROW_W - vffp_pkg::ROW2_W)'(0), i_word.row2};
        w_rows[3] = {(vffp_pkg::ROW_W - vffp_pkg::ROW3_W)'(0), i_word.row3};
        for (int i = 0; i < vffp_pkg::FRAME_W; i++) begin
            w_bits[i] = w_rows[vffp_pkg::ROW_SEL[i]][vffp_pkg::COL_SEL[i]];
        end
        n_word.frame_byte_0 = w_bits[7:0];
        n_word.frame_byte_1 = w_bits[15:8];
        n_word.frame_byte_2 = w_bits[23:16];
        n_word.frame_byte_3 = w_bits[31:24];
        n_word.frame_byte_4 = w_bits[39:32];
        n_word.frame_byte_5 = w_bits[47:40];
        n_word.frame_byte_6 = w_bits[55:48];
        n_word.frame_byte_7 = w_bits[63:56];
        n_word.frame_byte_8 = w_bits[71:64];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
`default_nettype wire
